// ===== hdl/crcgc_pkg.sv =====
// shared types and constants for the programmable crc generator and checker
`timescale 1ns / 1ps
`default_nettype none
package crcgc_pkg;

  localparam int TAPS_W  = 32;
  localparam int DEG_W   = 6;
  localparam int REM_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  // wide enough to hold any clamped degree up to 64
  localparam int EFF_W   = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAPS   = 2'd0,
    CFG_DEGREE = 2'd1,
    CFG_MODE   = 2'd2
  } cfg_index_t;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_CHECK  = 1'b1
  } crc_mode_t;

  // control broadcast to every cell of the remainder chain
  typedef struct packed {
    logic advance;
    logic feedback;
    logic clear;
  } cell_ctrl_t;

  // one result beat
  typedef struct packed {
    logic [REM_W-1:0] remainder;
    logic             error;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/crcgc_cell.sv =====
// one bit of the crc remainder chain
`timescale 1ns / 1ps
`default_nettype none
module crcgc_cell (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire crcgc_pkg::cell_ctrl_t ctrl,
  input  wire logic                  tap,
  input  wire logic                  enable,
  input  wire logic                  shift_in,
  output logic                       q
);
  import crcgc_pkg::*;

  logic q_next;

  // shifted bit, corrected by the generator tap when feedback fires
  assign q_next = (shift_in ^ (ctrl.feedback & tap)) & enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= 1'b0;
    end else if (ctrl.advance) begin
      if (ctrl.clear) begin
        q <= 1'b0;
      end else begin
        q <= q_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/crcgc_out_buf.sv =====
// two-deep result buffer: output register plus skid stage
`timescale 1ns / 1ps
`default_nettype none
module crcgc_out_buf (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire crcgc_pkg::result_t push_data,
  output logic                    full,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output crcgc_pkg::result_t      out_data
);
  import crcgc_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    out_pop;

  assign out_pop = out_valid && !out_stall;
  assign full    = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!out_valid || out_pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      if (!out_valid || out_pop) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end else if (out_pop && skid_valid) begin
      out_data <= skid_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("beat pushed into a full result buffer");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_pop && !push) |=> (out_valid && !skid_valid))
    else $error("skid beat not moved to output register");

endmodule
`default_nettype wire

// ===== hdl/crc_generate_and_check.sv =====
// top level of the programmable bit-serial crc generator and checker
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial crc with a programmable generator. Each input beat carries one
// message or codeword bit, most significant first. The remainder lives in a
// chain of MAX_DEGREE one-bit cells, each shifting into its neighbour with
// the generator tap folded in, so a new bit is taken each time in_stall is
// low. The leading generator term is implied by degree (clamped to
// 1..MAX_DEGREE); tap bits at or above the degree are ignored.
// In encode mode (mode 0) the bit enters through the feedback path, which
// equals dividing the message followed by degree zeros; in check mode
// (mode 1) the codeword is divided directly and error flags a nonzero
// remainder. On the beat marked last one result beat leaves with the
// remainder in its low degree bits, and the chain is cleared. Results pass
// through a two-deep buffer (output register and skid stage), so input
// beats keep flowing while a result waits; in_stall rises only when both
// stages hold a result. Configuration is written through cfg_write,
// cfg_index and cfg_data, and should be changed only between messages.
module crc_generate_and_check #(
  parameter int MAX_DEGREE = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration
  input  wire logic                             cfg_write,
  input  wire logic [crcgc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [crcgc_pkg::CFG_DATA_W-1:0] cfg_data,
  // input beats
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             data_bit,
  input  wire logic                             last,
  // result beats
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [crcgc_pkg::REM_W-1:0]           remainder,
  output logic                                  error
);
  import crcgc_pkg::*;

  // configuration registers
  logic [TAPS_W-1:0] generator_taps;
  logic [DEG_W-1:0]  degree;
  crc_mode_t         mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      generator_taps <= TAPS_W'(5);
      degree         <= DEG_W'(3);
      mode           <= MODE_ENCODE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TAPS:   generator_taps <= cfg_data[TAPS_W-1:0];
        CFG_DEGREE: degree         <= cfg_data[DEG_W-1:0];
        CFG_MODE:   mode           <= crc_mode_t'(cfg_data[0]);
        default:    ;
      endcase
    end
  end

  // effective degree, clamped to 1..MAX_DEGREE
  logic [EFF_W-1:0] eff_degree;
  always_comb begin
    eff_degree = EFF_W'(degree);
    if (eff_degree == '0) begin
      eff_degree = EFF_W'(1);
    end
    if (eff_degree > EFF_W'(MAX_DEGREE)) begin
      eff_degree = EFF_W'(MAX_DEGREE);
    end
  end

  // per-cell enable, tap and top select
  logic [MAX_DEGREE-1:0] cell_enable;
  logic [MAX_DEGREE-1:0] cell_tap;
  logic [MAX_DEGREE-1:0] top_sel;
  logic [MAX_DEGREE-1:0] state;
  logic [MAX_DEGREE-1:0] state_next;
  logic [MAX_DEGREE-1:0] shift_in;

  for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_lane
    assign cell_enable[i] = EFF_W'(i) < eff_degree;
    assign top_sel[i]     = EFF_W'(i) == (eff_degree - EFF_W'(1));
    if (i < TAPS_W) begin : g_tap
      assign cell_tap[i] = generator_taps[i];
    end else begin : g_no_tap
      assign cell_tap[i] = 1'b0;
    end
  end

  // bit leaving the top of the active remainder
  logic top_bit;
  assign top_bit = |(state & top_sel);

  logic       in_accept;
  cell_ctrl_t ctrl;

  assign in_accept     = in_valid && !in_stall;
  assign ctrl.advance  = in_accept;
  assign ctrl.clear    = last;
  // encode folds the data bit into feedback, check shifts it in at the bottom
  assign ctrl.feedback = (mode == MODE_CHECK) ? top_bit : (top_bit ^ data_bit);

  assign shift_in[0] = (mode == MODE_CHECK) ? data_bit : 1'b0;
  if (MAX_DEGREE > 1) begin : g_chain
    assign shift_in[MAX_DEGREE-1:1] = state[MAX_DEGREE-2:0];
  end

  // next remainder as seen by the result path
  assign state_next = (shift_in ^ ({MAX_DEGREE{ctrl.feedback}} & cell_tap)) & cell_enable;

  for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_cell
    crcgc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .tap      (cell_tap[i]),
      .enable   (cell_enable[i]),
      .shift_in (shift_in[i]),
      .q        (state[i])
    );
  end

  // result beat
  result_t res;
  for (genvar j = 0; j < REM_W; j++) begin : g_res
    if (j < MAX_DEGREE) begin : g_bit
      assign res.remainder[j] = state_next[j];
    end else begin : g_zero
      assign res.remainder[j] = 1'b0;
    end
  end
  assign res.error = (mode == MODE_CHECK) && (|state_next);

  logic    buf_full;
  result_t out_data;

  crcgc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept && last),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_stall  = buf_full;
  assign remainder = out_data.remainder;
  assign error     = out_data.error;

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last) |=> (state == '0))
    else $error("remainder chain not cleared after last beat");

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last) |=> out_valid)
    else $error("no result beat after last input beat");

  a_error_needs_remainder: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (remainder != '0))
    else $error("error flagged with zero remainder");

  a_hold_without_beat: assert property (@(posedge clk) disable iff (rst)
    (!in_accept && !$past(rst)) |=> $stable(state))
    else $error("remainder chain moved without an input beat");

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for the programmable bit-serial crc generator and checker
`timescale 1ns / 1ps
module testbench;
  import crcgc_pkg::*;

  localparam int MAX_DEG       = 32;
  localparam int SETTLE_CYCLES = 8;     // result path is two stages deep, allow a margin
  localparam int RANDOM_BEATS  = 2000;
  localparam int NUM_ROWS      = 32;

  // index with no register behind it, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic {
    ROW_BEAT,
    ROW_WRITE
  } row_kind_t;

  // one line of the directed script
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  value;
    logic                   bit_in;
    logic                   last_in;
    logic                   known;     // expected result typed in below
    result_t                want;
  } script_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TAPS;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic                  data_bit  = 1'b0;
  logic                  last      = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [REM_W-1:0]      remainder;
  logic                  error;

  // shadow copy of the block: registers and the running remainder
  logic [TAPS_W-1:0] gen_taps   = 32'd5;
  logic [DEG_W-1:0]  gen_degree = 6'd3;
  crc_mode_t         crc_mode   = MODE_ENCODE;
  logic [REM_W-1:0]  crc_reg    = '0;

  result_t owed_results [$];   // remainders still to come out, oldest first
  result_t last_result;        // most recent end-of-message result
  int      fail_count = 0;
  int      beats_sent = 0;
  int      sender_idle_pct   = 0;
  int      receiver_idle_pct = 0;

  crc_generate_and_check #(
    .MAX_DEGREE (MAX_DEG)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_bit  (data_bit),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .remainder (remainder),
    .error     (error)
  );

  always #5 clk = ~clk;

  // degree register saturates into 1..MAX_DEG
  function automatic int unsigned effective_degree(input logic [DEG_W-1:0] deg);
    int unsigned dg;
    dg = 32'(deg);
    if (dg < 1) dg = 1;
    if (dg > MAX_DEG) dg = MAX_DEG;
    return dg;
  endfunction

  // one step of the long division, clears the remainder on the closing bit
  function automatic result_t divide_bit(input logic d, input logic l);
    int unsigned       dg;
    logic [REM_W-1:0]  mask;
    logic [REM_W-1:0]  taps;
    logic [REM_W-1:0]  r;
    logic              top;
    result_t           res;
    dg   = effective_degree(gen_degree);
    mask = REM_W'((64'd1 << dg) - 64'd1);
    taps = gen_taps & mask;        // tap bits at or above the degree drop out
    r    = crc_reg & mask;
    top  = r[dg-1];
    if (crc_mode == MODE_ENCODE) begin
      // bit enters through the feedback path, same as appending degree zeros
      r = (r << 1) & mask;
      if (top ^ d) r = r ^ taps;
    end else begin
      // codeword is divided directly, bit enters at the bottom
      r = ((r << 1) | REM_W'(d)) & mask;
      if (top) r = r ^ taps;
    end
    crc_reg       = r;
    res.remainder = r;
    res.error     = (crc_mode == MODE_CHECK) && (r != '0);
    if (l) crc_reg = '0;
    return res;
  endfunction

  function automatic script_row_t bit_row(input logic d, input logic l);
    script_row_t row;
    row         = '0;
    row.kind    = ROW_BEAT;
    row.bit_in  = d;
    row.last_in = l;
    return row;
  endfunction

  function automatic script_row_t known_row(input logic d, input logic [REM_W-1:0] rem,
                                            input logic err);
    script_row_t row;
    row                = bit_row(d, 1'b1);
    row.known          = 1'b1;
    row.want.remainder = rem;
    row.want.error     = err;
    return row;
  endfunction

  function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] v);
    script_row_t row;
    row       = '0;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.value = v;
    return row;
  endfunction

  // directed script: extremes, both modes, saturation and the awkward corners
  script_row_t script [NUM_ROWS] = '{
    // straight after reset: taps 5, degree 3, encode
    known_row(1'b0, 32'h0, 1'b0),
    known_row(1'b1, 32'h5, 1'b0),
    // widest remainder with every tap set
    reg_row(CFG_DEGREE, 32'd32),
    reg_row(CFG_TAPS, 32'hFFFF_FFFF),
    known_row(1'b1, 32'hFFFF_FFFF, 1'b0),
    bit_row(1'b1, 1'b0),
    bit_row(1'b0, 1'b0),
    bit_row(1'b1, 1'b0),
    bit_row(1'b1, 1'b1),
    // check mode, single bit codewords
    reg_row(CFG_MODE, 32'(MODE_CHECK)),
    known_row(1'b1, 32'h1, 1'b1),
    known_row(1'b0, 32'h0, 1'b0),
    // degree zero saturates to one, upper taps are ignored
    reg_row(CFG_DEGREE, 32'd0),
    known_row(1'b1, 32'h1, 1'b1),
    reg_row(CFG_MODE, 32'(MODE_ENCODE)),
    known_row(1'b1, 32'h1, 1'b0),
    // degree above the maximum saturates
    reg_row(CFG_DEGREE, 32'd63),
    reg_row(CFG_TAPS, 32'h8000_0001),
    known_row(1'b1, 32'h8000_0001, 1'b0),
    reg_row(CFG_DEGREE, 32'd33),
    bit_row(1'b0, 1'b0),
    bit_row(1'b1, 1'b1),
    // no taps at all
    reg_row(CFG_TAPS, 32'h0),
    known_row(1'b1, 32'h0, 1'b0),
    // write to the unused index
    reg_row(CFG_SPARE, 32'hFFFF_FFFF),
    // mode flipped halfway through a message
    reg_row(CFG_DEGREE, 32'd3),
    reg_row(CFG_TAPS, 32'd5),
    bit_row(1'b1, 1'b0),
    reg_row(CFG_MODE, 32'(MODE_CHECK)),
    bit_row(1'b0, 1'b1),
    reg_row(CFG_MODE, 32'(MODE_ENCODE)),
    known_row(1'b1, 32'h5, 1'b0)
  };

  // wait until every owed result has left, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only ever done with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      CFG_TAPS:   gen_taps   = v;
      CFG_DEGREE: gen_degree = v[DEG_W-1:0];
      CFG_MODE:   crc_mode   = crc_mode_t'(v[0]);
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // one input beat; valid is only dropped when a gap is taken
  task automatic send_bit(input logic d, input logic l, input logic known, input result_t want);
    result_t res;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    data_bit <= d;
    last     <= l;
    do @(posedge clk); while (in_stall);
    res = divide_bit(d, l);
    beats_sent++;
    if (l) begin
      last_result = res;
      owed_results.push_back(known ? want : res);
    end
  endtask

  task automatic send_random_bits(input int n, input logic noisy);
    for (int i = 0; i < n; i++)
      send_bit(1'($urandom_range(1)),
               (i == n - 1) || (noisy && $urandom_range(7) == 0), 1'b0, '0);
  endtask

  // encode a message, then feed message plus crc back in check mode,
  // now and then with one bit flipped
  task automatic round_trip(input int n);
    logic [127:0]      msg;
    logic [31:0]       junk;
    logic [REM_W-1:0]  crc;
    int unsigned       dg;
    int                flip;
    logic              b;
    msg  = {$urandom, $urandom, $urandom, $urandom};
    junk = $urandom;
    if (crc_mode != MODE_ENCODE) write_reg(CFG_MODE, {junk[31:1], MODE_ENCODE});
    for (int i = 0; i < n; i++) send_bit(msg[n-1-i], i == n - 1, 1'b0, '0);
    crc = last_result.remainder;
    dg  = effective_degree(gen_degree);
    write_reg(CFG_MODE, {junk[31:1], MODE_CHECK});
    flip = ($urandom_range(3) == 0) ? int'($urandom_range(n + dg - 1)) : -1;
    for (int i = 0; i < n + int'(dg); i++) begin
      b = (i < n) ? msg[n-1-i] : crc[dg-1-(i-n)];
      if (i == flip) b = ~b;
      send_bit(b, i == n + int'(dg) - 1, 1'b0, '0);
    end
  endtask

  // fresh generator setting, degree upper data bits carry junk
  task automatic new_setting();
    logic [31:0]      junk;
    logic [DEG_W-1:0] deg;
    logic [31:0]      taps;
    junk = $urandom;
    case ($urandom_range(9))
      0:       deg = 6'd1;
      1:       deg = 6'(MAX_DEG);
      2:       deg = 6'd0;
      3:       deg = 6'($urandom_range(MAX_DEG + 1, 63));
      default: deg = 6'($urandom_range(2, MAX_DEG - 1));
    endcase
    case ($urandom_range(7))
      0:       taps = 32'h0;
      1:       taps = 32'hFFFF_FFFF;
      default: taps = $urandom;
    endcase
    write_reg(CFG_DEGREE, {junk[31:DEG_W], deg});
    write_reg(CFG_TAPS, taps);
    write_reg(CFG_MODE, {junk[31:1], MODE_ENCODE});
  endtask

  // receiver: stalls at random
  always @(posedge clk) out_stall <= ($urandom_range(99) < receiver_idle_pct);

  // result checker: every accepted beat against the oldest owed result
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result beat: remainder %h error %b", remainder, error);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        if (remainder !== want.remainder) begin
          $error("remainder: expected %h, got %h", want.remainder, remainder);
          fail_count++;
        end
        if (error !== want.error) begin
          $error("error: expected %b, got %b", want.error, error);
          fail_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    int target;
    int n;
    int pick;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed script, sender idles lightly, receiver heavily
    sender_idle_pct   = 21;
    receiver_idle_pct = 87;
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE)
        write_reg(script[i].idx, script[i].value);
      else
        send_bit(script[i].bit_in, script[i].last_in, script[i].known, script[i].want);
    end

    // random part in three idling phases
    target = beats_sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct   = 21;
          receiver_idle_pct = 87;
        end
        1: begin
          sender_idle_pct   = 87;
          receiver_idle_pct = 21;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      target += RANDOM_BEATS / 3;
      while (beats_sent < target) begin
        new_setting();
        repeat ($urandom_range(3, 8)) begin
          // mostly short messages, a few long ones
          n    = ($urandom_range(9) == 0) ? $urandom_range(25, 96) : $urandom_range(1, 24);
          pick = $urandom_range(99);
          if ($urandom_range(19) == 0) settle();   // sender holds off until all is out
          if (pick < 60)
            round_trip(n);
          else if (pick < 85)
            send_random_bits(n, 1'b0);
          else
            send_random_bits(n, 1'b1);             // noise: stray last marks
        end
      end
    end

    settle();
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/crcgc_pkg.sv
hdl/crcgc_cell.sv
hdl/crcgc_out_buf.sv
hdl/crc_generate_and_check.sv
sim/testbench.sv
